[hw/rtl/flash_sector_remap_table_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the flash sector remap table
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FLASH_SECTOR_REMAP_TABLE_DEFINES_SVH
`define FLASH_SECTOR_REMAP_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define FSRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define FSRT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FSRT_ASSERT(label, clk, rst_n, prop, msg)
`define FSRT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/fsrt_pkg.sv]
// ----------------------------------------------------------------------------
// fsrt_pkg
// Shared types, codes and defaults of the flash sector remap table.
// ----------------------------------------------------------------------------
`default_nettype none

package fsrt_pkg;

    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int SECTOR_BYTES_DEF = 256 * 16;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMAP  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_RANGE   = 2'd1;
    localparam logic [1:0] STAT_NOSPARE = 2'd2;

    localparam logic [1:0] CFG_LOGICAL_COUNT = 2'd0;
    localparam logic [1:0] CFG_SPARE_FIRST   = 2'd1;
    localparam logic [1:0] CFG_TABLE_FIRST   = 2'd2;
    localparam logic [1:0] CFG_DISK_BASE     = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] lba;
        logic [15:0] val;
        logic        range_err;
        logic [16:0] tsec;
    } fsrt_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_ALLOC,
        BK_DONE
    } fsrt_bk_state_t;

endpackage

`default_nettype wire

[hw/rtl/fsrt_ram.sv]
// ----------------------------------------------------------------------------
// fsrt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata <= mem_reg[addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fsrt_front.sv]
// ----------------------------------------------------------------------------
// fsrt_front
// Request intake: range check, write-back sector, short request queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flash_sector_remap_table_defines.svh"

module fsrt_front #(
    parameter int TABLE_DEPTH  = fsrt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTOR_BYTES = fsrt_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,  // logical_sector, entry_value
    input  wire logic [1:0]                       s_tuser,  // req_type
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] limit,
    input  wire logic [15:0]                      table_first,
    output fsrt_pkg::fsrt_cmd_t                   head,
    output logic                                  head_valid,
    input  wire logic                             pop
);

    import fsrt_pkg::*;

    localparam int TS_SHIFT = $clog2(SECTOR_BYTES / 2);
    localparam int QPW      = $clog2(QUEUE_DEPTH);
    localparam int QCW      = $clog2(QUEUE_DEPTH + 1);

    fsrt_cmd_t        q_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    fsrt_cmd_t        cmd_in;
    logic             push;
    logic [15:0]      lba;

    assign lba = s_tdata[15:0];

    always_comb begin
        cmd_in.req       = s_tuser;
        cmd_in.lba       = lba;
        cmd_in.val       = s_tdata[31:16];
        cmd_in.range_err = !(17'(lba) < 17'(limit));
        // entries per table sector is a power of two
        cmd_in.tsec      = 17'(table_first) + 17'(lba >> TS_SHIFT);
    end

    assign s_tready   = (count_reg != QCW'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCW'(1);
                2'b01:   count_reg <= count_reg - QCW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    `FSRT_ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && (count_reg == '0), "pop from empty queue")
    `FSRT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QCW'(QUEUE_DEPTH), "queue overflow")

endmodule

`default_nettype wire

[hw/rtl/fsrt_back.sv]
// ----------------------------------------------------------------------------
// fsrt_back
// Request execution: table access, spare scan and allocation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flash_sector_remap_table_defines.svh"

module fsrt_back #(
    parameter int TABLE_DEPTH  = fsrt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTOR_BYTES = fsrt_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire fsrt_pkg::fsrt_cmd_t              head,
    input  wire logic                             head_valid,
    output logic                                  pop,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] limit,
    input  wire logic [15:0]                      spare_first,
    input  wire logic [15:0]                      table_first,
    input  wire logic [31:0]                      disk_base_address,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [71:0]                      m_tdata,  // physical_sector, byte_address,
                                                            // table_sector
    output logic      [1:0]                       m_tuser   // status
);

    import fsrt_pkg::*;

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int LW       = $clog2(TABLE_DEPTH + 1);
    localparam int SB_SHIFT = $clog2(SECTOR_BYTES);

    fsrt_bk_state_t state_reg, state_next;

    logic [AW-1:0] lba_reg, lba_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   phys_reg, phys_next;
    logic [16:0]   tsec_reg, tsec_next;
    logic          use_rd_reg, use_rd_next;
    logic [LW-1:0] scan_addr_reg, scan_addr_next;
    logic          scan_rv_reg, scan_rv_next;
    logic [15:0]   max_reg, max_next;
    logic [15:0]   cand_reg, cand_next;
    logic [15:0]   last_spare_reg, last_spare_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [71:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [15:0]   max_upd, cand_inc, phys_out;
    logic [31:0]   addr_out;

    fsrt_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            scan_rv_reg    <= 1'b0;
            last_spare_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_rv_reg    <= scan_rv_next;
            last_spare_reg <= last_spare_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lba_reg       <= lba_next;
        status_reg    <= status_next;
        phys_reg      <= phys_next;
        tsec_reg      <= tsec_next;
        use_rd_reg    <= use_rd_next;
        scan_addr_reg <= scan_addr_next;
        max_reg       <= max_next;
        cand_reg      <= cand_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign max_upd  = (scan_rv_reg && (ram_rdata > max_reg)) ? ram_rdata : max_reg;
    assign cand_inc = cand_reg + 16'd1;
    assign phys_out = use_rd_reg ? ram_rdata : phys_reg;
    assign addr_out = (status_reg == STAT_OK)
                    ? disk_base_address + (32'(phys_out) << SB_SHIFT) : 32'd0;

    always_comb begin
        state_next      = state_reg;
        lba_next        = lba_reg;
        status_next     = status_reg;
        phys_next       = phys_reg;
        tsec_next       = tsec_reg;
        use_rd_next     = use_rd_reg;
        scan_addr_next  = scan_addr_reg;
        scan_rv_next    = scan_rv_reg;
        max_next        = max_reg;
        cand_next       = cand_reg;
        last_spare_next = last_spare_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        pop             = 1'b0;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = head.lba[AW-1:0];
        ram_wdata       = head.val;

        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    pop         = 1'b1;
                    lba_next    = head.lba[AW-1:0];
                    tsec_next   = head.tsec;
                    status_next = STAT_OK;
                    phys_next   = '0;
                    use_rd_next = 1'b0;
                    if (head.range_err) begin
                        status_next = STAT_RANGE;
                        tsec_next   = '0;
                        state_next  = BK_DONE;
                    end else begin
                        case (head.req)
                            REQ_LOAD: begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                phys_next  = head.val;
                                state_next = BK_DONE;
                            end
                            REQ_REMAP: begin
                                if (last_spare_reg != '0) begin
                                    cand_next  = last_spare_reg;
                                    state_next = BK_ALLOC;
                                end else begin
                                    scan_addr_next = '0;
                                    scan_rv_next   = 1'b0;
                                    max_next       = '0;
                                    state_next     = BK_SCAN;
                                end
                            end
                            default: begin
                                // lookup; selector three behaves the same
                                ram_en      = 1'b1;
                                use_rd_next = 1'b1;
                                state_next  = BK_DONE;
                            end
                        endcase
                    end
                end
            end

            BK_SCAN: begin
                // one read issued per cycle, data compared in the next cycle
                max_next = max_upd;
                if (scan_addr_reg < limit) begin
                    ram_en         = 1'b1;
                    ram_addr       = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + LW'(1);
                    scan_rv_next   = 1'b1;
                end else begin
                    scan_rv_next = 1'b0;
                    if (!scan_rv_reg) begin
                        cand_next  = (max_upd < spare_first) ? spare_first - 16'd1 : max_upd;
                        state_next = BK_ALLOC;
                    end
                end
            end

            BK_ALLOC: begin
                if ((cand_inc == '0) || (cand_inc >= table_first)) begin
                    status_next = STAT_NOSPARE;
                    tsec_next   = '0;
                    phys_next   = '0;
                end else begin
                    ram_en          = 1'b1;
                    ram_we          = 1'b1;
                    ram_addr        = lba_reg;
                    ram_wdata       = cand_inc;
                    last_spare_next = cand_inc;
                    phys_next       = cand_inc;
                end
                state_next = BK_DONE;
            end

            BK_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, tsec_reg, addr_out, phys_out};
                    m_tuser_next  = status_reg;
                    state_next    = BK_IDLE;
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FSRT_ASSERT(a_scan_fresh, aclk, aresetn, (state_reg == BK_SCAN) |-> (last_spare_reg == '0), "scan with spare in use")
    `FSRT_ASSERT(a_scan_bound, aclk, aresetn, (state_reg == BK_SCAN) |-> (scan_addr_reg <= limit), "scan past limit")
    `FSRT_ASSERT_NEVER(a_err_payload, aclk, aresetn, m_tvalid_reg && (m_tuser_reg != STAT_OK) && (m_tdata_reg != '0), "error result with payload")

endmodule

`default_nettype wire

[hw/rtl/flash_sector_remap_table.sv]
// ----------------------------------------------------------------------------
// flash_sector_remap_table
// Logical-to-physical flash sector table with spare-sector remapping.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (tuser = req_type, tdata = logical_sector,
//   entry_value); each gives exactly one result on the m_ stream (tuser = status,
//   tdata = physical_sector, byte_address, table_sector).
//   Config registers are written through cfg_wr_en / cfg_index / cfg_wr_data;
//   the user must write them only while no request is outstanding (not enforced).
//   Load, lookup and out-of-range requests take the execution steps dispatch
//   (with the table access for load and lookup), then result register; a remap
//   with a spare in use adds an allocate step between them. All table accesses
//   go through the single table RAM port, whose read data is registered. A remap
//   while no spare is in use (after reset, until an allocation succeeds) scans
//   entries 0 .. limit-1 through the same port.
//   A two-entry request queue keeps the input side taking requests while the
//   executor works or a result is held; when the receiver stalls, the result
//   register holds, the queue fills, then s_tready drops.
//   Reset (aresetn low, synchronous) empties the queue, drops m_tvalid, marks no
//   spare used and restores the register defaults; table contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_sector_remap_table #(
    parameter int TABLE_DEPTH  = fsrt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTOR_BYTES = fsrt_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // logical_sector[15:0], entry_value[31:16]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // physical_sector[15:0], byte_address[47:16],
                                        // table_sector[64:48], zero pad
    output logic      [1:0]  m_tuser    // status[1:0]
);

    import fsrt_pkg::*;

    localparam int LW = $clog2(TABLE_DEPTH + 1);

    logic [12:0]   logical_count_reg;
    logic [15:0]   spare_first_reg;
    logic [15:0]   table_first_reg;
    logic [31:0]   disk_base_reg;
    logic [LW-1:0] limit;
    fsrt_cmd_t     head;
    logic          head_valid;
    logic          pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logical_count_reg <= '0;
            spare_first_reg   <= 16'd1;
            table_first_reg   <= '0;
            disk_base_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOGICAL_COUNT: logical_count_reg <= cfg_wr_data[12:0];
                CFG_SPARE_FIRST:   spare_first_reg   <= cfg_wr_data[15:0];
                CFG_TABLE_FIRST:   table_first_reg   <= cfg_wr_data[15:0];
                CFG_DISK_BASE:     disk_base_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // entries in range: below both logical_count and the table depth
    assign limit = (17'(logical_count_reg) < 17'(TABLE_DEPTH))
                 ? LW'(logical_count_reg) : LW'(TABLE_DEPTH);

    fsrt_front #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .limit       (limit),
        .table_first (table_first_reg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop)
    );

    fsrt_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (head),
        .head_valid        (head_valid),
        .pop               (pop),
        .limit             (limit),
        .spare_first       (spare_first_reg),
        .table_first       (table_first_reg),
        .disk_base_address (disk_base_reg),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

endmodule

`default_nettype wire
